// ----- hdl/aes_pkg.sv -----
// aes_pkg: shared constants, types and round functions of the aes block cipher
`timescale 1ns / 1ps

package aes_pkg;

  localparam int MAX_ROUNDS = 14;
  localparam int ROWS       = MAX_ROUNDS + 1;
  localparam int ROW_W      = $clog2(ROWS);

  // register indexes of the configuration port
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  // key length modes
  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] POLY       = 8'h1b;
  localparam logic [7:0] TOP_BIT    = 8'h80;

  typedef struct packed {
    logic             load;
    logic             first;
    logic             round;
    logic             last;
    logic             dec;
    logic             capture;
    logic [ROW_W-1:0] rd_addr;
    logic             kx_step;
    logic             kx_start;
    logic             kx_load;
    logic             kx_rot;
    logic             kx_sub;
    logic             kx_wr;
    logic [5:0]       kx_idx;
  } ctrl_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (((x & TOP_BIT) != 8'h00) ? POLY : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    return o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[127-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r + 4*c);
        end else begin
          o[127-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c+r)%4));
        end
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0]   a [4];
    logic [7:0]   a2 [4];
    logic [7:0]   a4 [4];
    logic [7:0]   a8 [4];
    logic [7:0]   m0, m1, m2, m3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = get_byte(s, 4*c + k);
        a2[k] = xt(a[k]);
        a4[k] = xt(a2[k]);
        a8[k] = xt(a4[k]);
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          // 14, 11, 13, 9
          m0 = a8[r] ^ a4[r] ^ a2[r];
          m1 = a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4];
          m2 = a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4];
          m3 = a8[(r+3)%4] ^ a[(r+3)%4];
        end else begin
          // 2, 3, 1, 1
          m0 = a2[r];
          m1 = a2[(r+1)%4] ^ a[(r+1)%4];
          m2 = a[(r+2)%4];
          m3 = a[(r+3)%4];
        end
        o[127-8*(4*c+r) -: 8] = m0 ^ m1 ^ m2 ^ m3;
      end
    end
    return o;
  endfunction

endpackage

// ----- hdl/aes_ctrl.sv -----
// aes_ctrl: sequencer for key expansion, cipher rounds and result handoff
`timescale 1ns / 1ps

module aes_ctrl import aes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  logic       cfg_start,
  input  logic       block_valid,
  output logic       block_ready,
  input  logic       command,
  output logic       result_valid,
  input  logic       result_ready,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {EXPAND, IDLE, RUN, FLUSH} state_t;

  state_t     state;
  logic [5:0] widx;
  logic [2:0] wmod;
  logic [3:0] rnd;
  logic       dec;

  logic [3:0] nr;
  logic [2:0] nk_last;
  logic [5:0] w_last;
  logic       kx_load;
  logic       out_free;
  logic       fill_out;

  assign nr       = 4'd10 + {1'b0, mode, 1'b0};
  assign nk_last  = 3'd3 + {mode, 1'b0};
  assign w_last   = {nr, 2'b11};
  assign kx_load  = (widx < {2'b00, nk_last} + 6'd1);
  assign out_free = !result_valid || result_ready;
  assign fill_out = !cfg_start && (state == FLUSH) && out_free;

  assign block_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.dec      = dec;
    cmd.last     = (rnd == nr);
    cmd.kx_idx   = widx;
    cmd.kx_load  = kx_load;
    case (state)
      EXPAND: begin
        cmd.kx_step  = 1'b1;
        cmd.kx_start = (widx == 6'd0);
        cmd.kx_rot   = !kx_load && (wmod == 3'd0);
        cmd.kx_sub   = !kx_load && (mode == MODE_256) && (wmod == 3'd4);
        cmd.kx_wr    = (widx[1:0] == 2'b11);
      end
      IDLE: begin
        cmd.load    = block_valid;
        cmd.rd_addr = command ? ROW_W'(nr) : '0;
      end
      RUN: begin
        cmd.first   = (rnd == 4'd0);
        cmd.round   = (rnd != 4'd0);
        cmd.rd_addr = dec ? ROW_W'(nr - rnd - 4'd1) : ROW_W'(rnd + 4'd1);
      end
      FLUSH: begin
        cmd.capture = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= EXPAND;
      widx         <= '0;
      wmod         <= '0;
      rnd          <= '0;
      dec          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (fill_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_start) begin
        state <= EXPAND;
        widx  <= '0;
        wmod  <= '0;
      end else begin
        case (state)
          EXPAND: begin
            widx <= widx + 6'd1;
            wmod <= (wmod == nk_last) ? 3'd0 : wmod + 3'd1;
            if (widx == w_last) begin
              state <= IDLE;
            end
          end
          IDLE: begin
            if (block_valid) begin
              dec   <= command;
              rnd   <= '0;
              state <= RUN;
            end
          end
          RUN: begin
            if (rnd == nr) begin
              state <= FLUSH;
            end else begin
              rnd <= rnd + 4'd1;
            end
          end
          FLUSH: begin
            if (out_free) begin
              state <= IDLE;
            end
          end
          default: state <= IDLE;
        endcase
      end
    end
  end

endmodule

// ----- hdl/aes_dp.sv -----
// aes_dp: key expansion, round key store, round logic and result register
`timescale 1ns / 1ps

module aes_dp import aes_pkg::*; (
  input  logic         clk,
  input  logic [1:0]   mode,
  input  logic [255:0] key,
  input  logic [63:0]  block_hi,
  input  logic [63:0]  block_lo,
  input  ctrl_cmd_t    cmd,
  output logic [63:0]  result_hi,
  output logic [63:0]  result_lo
);

  logic [127:0] key_mem [ROWS];
  logic [127:0] rk;
  logic [127:0] s;
  logic [31:0]  win [8];
  logic [7:0]   rc;

  logic [31:0]  w_back;
  logic [31:0]  t;
  logic [31:0]  w_new;
  logic [63:0]  kw;
  logic [127:0] enc_sr;
  logic [127:0] enc_next;
  logic [127:0] dec_ark;
  logic [127:0] dec_next;

  // key word i-nk from the window
  always_comb begin
    case (mode)
      MODE_128: w_back = win[3];
      MODE_192: w_back = win[5];
      default:  w_back = win[7];
    endcase
  end

  always_comb begin
    kw = key[255 - 64*cmd.kx_idx[2:1] -: 64];
    if (cmd.kx_rot) begin
      t = sub_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h000000};
    end else if (cmd.kx_sub) begin
      t = sub_word(win[0]);
    end else begin
      t = win[0];
    end
    if (cmd.kx_load) begin
      w_new = cmd.kx_idx[0] ? kw[31:0] : kw[63:32];
    end else begin
      w_new = w_back ^ t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kx_step) begin
      win[0] <= w_new;
      for (int k = 1; k < 8; k++) begin
        win[k] <= win[k-1];
      end
      if (cmd.kx_start) begin
        rc <= RCON_FIRST;
      end else if (cmd.kx_rot) begin
        rc <= xt(rc);
      end
    end
    if (cmd.kx_wr) begin
      key_mem[cmd.kx_idx[ROW_W+1:2]] <= {win[2], win[1], win[0], w_new};
    end
    rk <= key_mem[cmd.rd_addr];
  end

  always_comb begin
    enc_sr   = shift_rows(sub_bytes(s, 1'b0), 1'b0);
    enc_next = (cmd.last ? enc_sr : mix_columns(enc_sr, 1'b0)) ^ rk;
    dec_ark  = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ rk;
    dec_next = cmd.last ? dec_ark : mix_columns(dec_ark, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s <= {block_hi, block_lo};
    end else if (cmd.first) begin
      s <= s ^ rk;
    end else if (cmd.round) begin
      s <= cmd.dec ? dec_next : enc_next;
    end
    if (cmd.capture) begin
      result_hi <= s[127:64];
      result_lo <= s[63:0];
    end
  end

endmodule

// ----- hdl/aes_block_cipher.sv -----
// aes_block_cipher: top level with configuration registers, sequencer and datapath
`timescale 1ns / 1ps

// AES block cipher in ECB form for 128, 192 and 256 bit keys. The key and
// key length mode are written over the APB port (64-bit registers at byte
// addresses 8*i: mode, then key words 0 to 3). Every effective register write,
// and reset, starts a key expansion that produces one 32-bit key word per
// cycle until all round keys for the key size are stored; during it no block
// word is taken. An accepted block is loaded, gets the initial key add, then
// runs its nr rounds, where nr is 10, 12 or 14, one after another through
// the shared round unit, and its state then moves into the output register
// once that register is free. The next block word is taken only after that
// move, so a new block never starts while the last one is in its rounds.
// The round key store is read one row per cycle through a registered port.
// A finished result waits in the output register while the next block word
// is accepted.

module aes_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // block channel
  input  logic        block_valid,
  output logic        block_ready,
  input  logic        command,
  input  logic [63:0] block_hi,
  input  logic [63:0] block_lo,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] result_hi,
  output logic [63:0] result_lo
);

  logic [1:0]  mode;
  logic [63:0] key_word [4];
  logic [2:0]  reg_idx;
  logic        wr_en;
  logic        mode_ok;
  logic        cfg_start;
  ctrl_cmd_t   cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  // a mode of 3, or one past the round budget, is dropped
  assign mode_ok = (pwdata[1:0] != 2'd3) &&
                   ((32'd10 + 32'(pwdata[1:0]) * 32'd2) <= 32'(MAX_ROUNDS));

  always_comb begin
    case (reg_idx)
      REG_MODE: cfg_start = wr_en && mode_ok;
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: cfg_start = wr_en;
      default:  cfg_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_128;
      for (int k = 0; k < 4; k++) begin
        key_word[k] <= '0;
      end
    end else if (cfg_start) begin
      if (reg_idx == REG_MODE) begin
        mode <= pwdata[1:0];
      end else begin
        key_word[2'(reg_idx - REG_KEY0)] <= pwdata;
      end
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_MODE: prdata = {62'd0, mode};
      REG_KEY0: prdata = key_word[0];
      REG_KEY1: prdata = key_word[1];
      REG_KEY2: prdata = key_word[2];
      REG_KEY3: prdata = key_word[3];
      default:  prdata = '0;
    endcase
  end

  aes_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .cfg_start    (cfg_start),
    .block_valid  (block_valid),
    .block_ready  (block_ready),
    .command      (command),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  aes_dp u_dp (
    .clk       (clk),
    .mode      (mode),
    .key       ({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .block_hi  (block_hi),
    .block_lo  (block_lo),
    .cmd       (cmd),
    .result_hi (result_hi),
    .result_lo (result_lo)
  );

  // an accepted block word keeps the input closed while it is worked on
  assert property (@(posedge clk) disable iff (rst)
    (block_valid && block_ready) |=> !block_ready)
    else $error("block accepted while previous block still in rounds");

  // a key or mode write restarts key expansion and closes the input
  assert property (@(posedge clk) disable iff (rst)
    cfg_start |=> !block_ready)
    else $error("input open right after key change");

  // a fresh result only appears at the end of a block's rounds
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!block_ready))
    else $error("result raised while idle");

endmodule
